@@ rtl/core/sab_pkg.sv @@
`default_nettype none

package sab_pkg;

  // Default pool size and the fixed field widths of the ports.
  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = 10;
  localparam int OFFSET_W = 22;
  localparam int BYTES_W  = 13;

  localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd16;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic                status;
  } rsp_t;

  // Outcome of one command as seen by the result stage.
  typedef struct packed {
    logic granted;
    logic exhausted;
  } grant_t;

endpackage

`default_nettype wire

@@ rtl/core/slot_allocator_free_list_bump.sv @@
// A request taken by start is registered in req_v and req_q, passes the free
// list and gives its result, with done high, from the done and rsp registers.
// Throughput: one request per cycle; busy is never raised, and the link
// memory's single read port prefetches the successor of the list head.
// Reset (synchronous, rst high) empties the free list, zeroes the bump cursor
// and sets slot_bytes to 16. The receiver cannot stall results.
`default_nettype none

module slot_allocator_free_list_bump #(
  parameter int CAPACITY = sab_pkg::CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire sab_pkg::req_t                 req,
  output logic                               done,
  output sab_pkg::rsp_t                      rsp,
  input  wire logic                          cfg_we,
  input  wire logic [sab_pkg::BYTES_W-1:0]   cfg_data
);

  localparam int AW = $clog2(CAPACITY);

  logic                           req_v;
  sab_pkg::req_t                  req_q;
  logic [sab_pkg::BYTES_W-1:0]    slot_bytes;
  sab_pkg::grant_t                grant;
  logic [AW-1:0]                  slot;
  logic [AW+sab_pkg::BYTES_W-1:0] product;

  // Every stage advances each cycle, so requests are never held off.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v      <= 1'b0;
      slot_bytes <= sab_pkg::BYTES_RESET;
    end else begin
      req_v <= start && !busy;
      if (cfg_we) begin
        slot_bytes <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  sab_list #(
    .CAPACITY (CAPACITY)
  ) u_list (
    .clk        (clk),
    .rst        (rst),
    .valid      (req_v),
    .command    (req_q.command),
    .slot_index (req_q.slot_index),
    .grant      (grant),
    .slot       (slot)
  );

  assign product = AW'(slot) * (AW + sab_pkg::BYTES_W)'(slot_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_v;
    end
  end

  always_ff @(posedge clk) begin
    rsp.status <= grant.exhausted;
    if (grant.granted) begin
      rsp.granted_slot <= sab_pkg::SLOT_W'(slot);
      rsp.byte_offset  <= sab_pkg::OFFSET_W'(product);
    end else begin
      rsp.granted_slot <= '0;
      rsp.byte_offset  <= '0;
    end
  end

  // A request taken now is answered, with done high, after the req_v and done registers.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted request produced no result");

  // An exhausted pool hands out nothing.
  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status) |-> (rsp.granted_slot == '0 && rsp.byte_offset == '0))
    else $error("exhausted allocate carried a slot");

  // Only an allocate can report exhaustion or a non-zero offset.
  assert property (@(posedge clk) disable iff (rst)
    (req_v && req_q.command != sab_pkg::CMD_ALLOC)
      |=> (!rsp.status && rsp.byte_offset == '0 && rsp.granted_slot == '0))
    else $error("non-allocate request returned a grant");

endmodule

`default_nettype wire

@@ rtl/core/sab_link_ram.sv @@
`default_nettype none

module sab_link_ram #(
  parameter int DEPTH = sab_pkg::CAPACITY,
  parameter int WIDTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a prefetched link stays usable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sab_list.sv @@
`default_nettype none

module sab_list #(
  parameter int CAPACITY = sab_pkg::CAPACITY,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          valid,
  input  wire logic [1:0]                    command,
  input  wire logic [sab_pkg::SLOT_W-1:0]    slot_index,
  output sab_pkg::grant_t                    grant,
  output logic      [AW-1:0]                 slot
);

  logic          list_empty, list_empty_next;
  logic [AW-1:0] head, head_next;
  logic          head_last, head_last_next;
  logic [AW-1:0] succ_reg, succ_reg_next;
  logic          succ_sel, succ_sel_next;
  logic [CW-1:0] cursor, cursor_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [AW:0]   ram_wdata, ram_rdata;

  logic [AW-1:0] succ;
  logic          head_l;
  logic          idx_ok, bump_back;

  // The link word of the head, its successor and its tail mark, is either
  // held in registers after a push or is the memory word fetched by the
  // previous pop.
  assign succ   = succ_sel ? ram_rdata[AW-1:0] : succ_reg;
  assign head_l = succ_sel ? ram_rdata[AW]     : head_last;

  assign idx_ok    = 32'(slot_index) < 32'(CAPACITY);
  assign bump_back = (cursor != '0) && (32'(slot_index) == 32'(cursor) - 32'd1);

  always_comb begin
    list_empty_next = list_empty;
    head_next       = head;
    head_last_next  = head_last;
    succ_reg_next   = succ_reg;
    succ_sel_next   = succ_sel;
    cursor_next     = cursor;
    ram_we          = 1'b0;
    ram_waddr       = AW'(slot_index);
    ram_wdata       = {list_empty, head};
    ram_re          = 1'b0;
    ram_raddr       = succ;
    grant           = '0;
    slot            = '0;
    if (valid) begin
      priority if (command == sab_pkg::CMD_ALLOC) begin
        if (!list_empty) begin
          grant.granted   = 1'b1;
          slot            = head;
          list_empty_next = head_l;
          head_next       = succ;
          ram_re          = 1'b1;
          succ_sel_next   = 1'b1;
        end else if (cursor < CW'(CAPACITY)) begin
          grant.granted = 1'b1;
          slot          = AW'(cursor);
          cursor_next   = cursor + CW'(1);
        end else begin
          grant.exhausted = 1'b1;
        end
      end else if (command == sab_pkg::CMD_FREE) begin
        if (idx_ok) begin
          if (bump_back) begin
            cursor_next = cursor - CW'(1);
          end else begin
            ram_we          = 1'b1;
            head_next       = AW'(slot_index);
            head_last_next  = list_empty;
            list_empty_next = 1'b0;
            succ_reg_next   = head;
            succ_sel_next   = 1'b0;
          end
        end
      end else if (command == sab_pkg::CMD_CLEAR) begin
        list_empty_next = 1'b1;
        head_next       = '0;
        cursor_next     = '0;
      end else begin
        list_empty_next = list_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_empty <= 1'b1;
      head       <= '0;
      head_last  <= 1'b0;
      succ_reg   <= '0;
      succ_sel   <= 1'b0;
      cursor     <= '0;
    end else begin
      list_empty <= list_empty_next;
      head       <= head_next;
      head_last  <= head_last_next;
      succ_reg   <= succ_reg_next;
      succ_sel   <= succ_sel_next;
      cursor     <= cursor_next;
    end
  end

  sab_link_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (AW + 1)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
